// ----- src/ccp_pkg.sv -----
// Shared types, widths and constants of the column precipitation partition block.
// No dependencies; every other file in src imports this package.
package ccp_pkg;

   // Field widths and fixed-point scaling
   localparam int WaterBits   = 24;
   localparam int TempBits    = 16;
   localparam int FracBits    = 17;
   localparam int FracShift   = 16;
   localparam int SupplyBits  = WaterBits + 1;
   localparam int SmoothShift = 2 * FracShift;

   localparam logic [FracBits-1:0] OneQ16       = FracBits'(1) << FracShift;
   localparam logic [FracBits-1:0] CritRhReset  = FracBits'(52429);
   // smoothstep weight is 3 - 2p, with 3.0 in Q16
   localparam logic [FracBits:0]   WeightBase   = (FracBits+1)'(3) << FracShift;

   // Phase divider: quotient is Q16, remainder as wide as a temperature span
   localparam int QuotBits     = FracShift;
   localparam int RemBits      = TempBits;
   localparam int BitsPerStage = 2;
   localparam int DivStages    = QuotBits / BitsPerStage;

   // Pipeline depths
   localparam int WaterStages = 4;
   localparam int ConvStages  = 4;
   localparam int AlignDepth  = DivStages + ConvStages - WaterStages;
   localparam int PipeLatency = DivStages + ConvStages + 2;

   // Register port
   localparam int CsrAddrBits = 5;
   localparam int CsrIdxBits  = 3;
   localparam int CsrDataBits = 32;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_CONV_FRAC = 3'd0,
      CSR_CRIT_RH   = 3'd1,
      CSR_RESID_RH  = 3'd2,
      CSR_CONV_EFF  = 3'd3,
      CSR_ACT_TEMP  = 3'd4,
      CSR_FULL_TEMP = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [WaterBits-1:0]        column_water;
      logic [WaterBits-1:0]        plain_capacity;
      logic [WaterBits-1:0]        terrain_capacity;
      logic signed [WaterBits-1:0] convergence;
      logic [WaterBits-1:0]        evaporation;
      logic signed [TempBits-1:0]  surface_temp;
   } ccp_req_type;

   typedef struct packed {
      logic [WaterBits-1:0] stratiform_rain;
      logic [WaterBits-1:0] orographic_rain;
      logic [WaterBits-1:0] convective_rain;
   } ccp_rsp_type;

   // Fraction registers after clamping to 1.0
   typedef struct packed {
      logic [FracBits-1:0] conv_frac;
      logic [FracBits-1:0] crit_rh;
      logic [FracBits-1:0] resid_rh;
      logic [FracBits-1:0] conv_eff;
   } ccp_cfg_type;

   // One slot of the phase divider pipeline
   typedef struct packed {
      logic                ge_hi;
      logic                zero;
      logic [RemBits-1:0]  rem;
      logic [QuotBits-1:0] quot;
   } ccp_phase_type;

   // Condensation results of the water path
   typedef struct packed {
      logic [WaterBits-1:0] strat;
      logic [WaterBits-1:0] oro;
      logic [WaterBits-1:0] conv_avail;
   } ccp_water_type;

   function automatic logic [FracBits-1:0] clamp_frac(input logic [FracBits-1:0] f);
      return (f > OneQ16) ? OneQ16 : f;
   endfunction

endpackage

// ----- src/ccp_phase_div.sv -----
// Pipelined restoring divider for the smoothstep phase (t - lo) * 65536 / (hi - lo).
// Two quotient bits per stage; depends on ccp_pkg.
module ccp_phase_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  ccp_pkg::ccp_phase_type        in_phase,
   input  logic [ccp_pkg::RemBits-1:0]   divisor,
   output logic                          out_valid,
   output logic [ccp_pkg::FracBits-1:0]  phase
);
   import ccp_pkg::*;

   logic [DivStages-1:0] vld_ff;
   logic [DivStages-1:0] vld_in;
   ccp_phase_type        st_ff [DivStages];
   ccp_phase_type        st_in [DivStages];
   ccp_phase_type        last;

   // Shift-and-subtract, BitsPerStage quotient bits
   function automatic ccp_phase_type div_step(input ccp_phase_type cur,
                                              input logic [RemBits-1:0] dvs);
      ccp_phase_type    nxt;
      logic [RemBits:0] shifted;
      logic             take;
      nxt = cur;
      for (int b = 0; b < BitsPerStage; b++) begin
         shifted  = {nxt.rem, 1'b0};
         take     = (shifted >= {1'b0, dvs});
         nxt.rem  = take ? RemBits'(shifted - {1'b0, dvs}) : shifted[RemBits-1:0];
         nxt.quot = {nxt.quot[QuotBits-2:0], take};
      end
      return nxt;
   endfunction

   // Next values of every stage
   always_comb begin
      vld_in   = {vld_ff[DivStages-2:0], in_valid};
      st_in[0] = div_step(in_phase, divisor);
      for (int k = 1; k < DivStages; k++) begin
         st_in[k] = div_step(st_ff[k-1], divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DivStages; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   // Saturated ends of the ramp override the quotient
   always_comb begin
      last      = st_ff[DivStages-1];
      out_valid = vld_ff[DivStages-1];
      if (last.ge_hi) begin
         phase = OneQ16;
      end else if (last.zero) begin
         phase = '0;
      end else begin
         phase = {1'b0, last.quot};
      end
   end

endmodule

// ----- src/ccp_water.sv -----
// Condensation path: stratiform and orographic amounts and the water left for convection.
// Four register stages, payload only; depends on ccp_pkg.
module ccp_water (
   input  logic                          clock,
   input  logic [ccp_pkg::WaterBits-1:0] avail,
   input  logic [ccp_pkg::WaterBits-1:0] plain,
   input  logic [ccp_pkg::WaterBits-1:0] terrain,
   input  ccp_pkg::ccp_cfg_type          cfg,
   output ccp_pkg::ccp_water_type        water
);
   import ccp_pkg::*;

   localparam int MulBits = WaterBits + FracBits;

   logic [MulBits-1:0]   thr_p_mul, thr_t_mul, flw_mul, cond_p_mul, cond_t_mul;
   logic [WaterBits-1:0] rem_w;

   // stage 1: humidity thresholds and residual floor
   logic [WaterBits-1:0] avail1_ff, avail1_in, thr_p_ff, thr_p_in, thr_t_ff, thr_t_in;
   logic [WaterBits-1:0] flw1_ff, flw1_in;
   // stage 2: excess over each threshold
   logic [WaterBits-1:0] avail2_ff, avail2_in, ex_p_ff, ex_p_in, ex_t_ff, ex_t_in;
   logic [WaterBits-1:0] flw2_ff, flw2_in;
   // stage 3: relaxed condensation
   logic [WaterBits-1:0] avail3_ff, avail3_in, cond_p_ff, cond_p_in, cond_t_ff, cond_t_in;
   logic [WaterBits-1:0] flw3_ff, flw3_in;
   // stage 4: split and convective headroom
   ccp_water_type        water_ff, water_in;

   always_comb begin
      thr_p_mul = MulBits'(plain) * MulBits'(cfg.crit_rh);
      thr_t_mul = MulBits'(terrain) * MulBits'(cfg.crit_rh);
      flw_mul   = MulBits'(plain) * MulBits'(cfg.resid_rh);
      avail1_in = avail;
      thr_p_in  = thr_p_mul[WaterBits+FracShift-1:FracShift];
      thr_t_in  = thr_t_mul[WaterBits+FracShift-1:FracShift];
      flw1_in   = flw_mul[WaterBits+FracShift-1:FracShift];
   end

   always_comb begin
      avail2_in = avail1_ff;
      flw2_in   = flw1_ff;
      ex_p_in   = (avail1_ff > thr_p_ff) ? avail1_ff - thr_p_ff : '0;
      ex_t_in   = (avail1_ff > thr_t_ff) ? avail1_ff - thr_t_ff : '0;
   end

   always_comb begin
      cond_p_mul = MulBits'(ex_p_ff) * MulBits'(cfg.conv_frac);
      cond_t_mul = MulBits'(ex_t_ff) * MulBits'(cfg.conv_frac);
      avail3_in  = avail2_ff;
      flw3_in    = flw2_ff;
      cond_p_in  = cond_p_mul[WaterBits+FracShift-1:FracShift];
      cond_t_in  = cond_t_mul[WaterBits+FracShift-1:FracShift];
   end

   // orographic is what only the terrain case condenses; stratiform the common part
   always_comb begin
      water_in.oro        = (cond_t_ff > cond_p_ff) ? cond_t_ff - cond_p_ff : '0;
      water_in.strat      = (cond_t_ff > cond_p_ff) ? cond_p_ff : cond_t_ff;
      rem_w               = (avail3_ff > cond_t_ff) ? avail3_ff - cond_t_ff : '0;
      water_in.conv_avail = (rem_w > flw3_ff) ? rem_w - flw3_ff : '0;
   end

   always_ff @(posedge clock) begin
      avail1_ff <= avail1_in;
      thr_p_ff  <= thr_p_in;
      thr_t_ff  <= thr_t_in;
      flw1_ff   <= flw1_in;
      avail2_ff <= avail2_in;
      ex_p_ff   <= ex_p_in;
      ex_t_ff   <= ex_t_in;
      flw2_ff   <= flw2_in;
      avail3_ff <= avail3_in;
      cond_p_ff <= cond_p_in;
      cond_t_ff <= cond_t_in;
      flw3_ff   <= flw3_in;
      water_ff  <= water_in;
   end

   assign water = water_ff;

endmodule

// ----- src/ccp_convect.sv -----
// Convective demand: cubic smoothstep of the phase, times supply, times efficiency.
// Four register stages with one multiplier each; depends on ccp_pkg.
module ccp_convect (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [ccp_pkg::FracBits-1:0]   phase,
   input  logic [ccp_pkg::SupplyBits-1:0] supply,
   input  logic [ccp_pkg::FracBits-1:0]   conv_eff,
   output logic                           out_valid,
   output logic [ccp_pkg::SupplyBits-1:0] demand
);
   import ccp_pkg::*;

   localparam int SqBits   = 2 * FracBits;
   localparam int CubeBits = SqBits + FracBits + 1;
   localparam int ScaBits  = SupplyBits + FracBits;

   logic [CubeBits-1:0]   cube_mul;
   logic [ScaBits-1:0]    sup_mul, eff_mul;

   logic [ConvStages-1:0] vld_ff, vld_in;
   // stage 1: p squared and the 3 - 2p weight
   logic [SqBits-1:0]     pp_ff, pp_in;
   logic [FracBits:0]     wt_ff, wt_in;
   logic [SupplyBits-1:0] sup1_ff, sup1_in;
   // stage 2: smoothstep value, Q16
   logic [FracBits-1:0]   ss_ff, ss_in;
   logic [SupplyBits-1:0] sup2_ff, sup2_in;
   // stage 3: supply scaled by instability
   logic [SupplyBits-1:0] scaled_ff, scaled_in;
   // stage 4: times efficiency
   logic [SupplyBits-1:0] dem_ff, dem_in;

   always_comb begin
      vld_in    = {vld_ff[ConvStages-2:0], in_valid};
      pp_in     = SqBits'(phase) * SqBits'(phase);
      wt_in     = WeightBase - {phase, 1'b0};
      sup1_in   = supply;

      cube_mul  = CubeBits'(pp_ff) * CubeBits'(wt_ff);
      ss_in     = cube_mul[SmoothShift+FracBits-1:SmoothShift];
      sup2_in   = sup1_ff;

      sup_mul   = ScaBits'(sup2_ff) * ScaBits'(ss_ff);
      scaled_in = sup_mul[SupplyBits+FracShift-1:FracShift];

      eff_mul   = ScaBits'(scaled_ff) * ScaBits'(conv_eff);
      dem_in    = eff_mul[SupplyBits+FracShift-1:FracShift];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff     <= pp_in;
      wt_ff     <= wt_in;
      sup1_ff   <= sup1_in;
      ss_ff     <= ss_in;
      sup2_ff   <= sup2_in;
      scaled_ff <= scaled_in;
      dem_ff    <= dem_in;
   end

   assign out_valid = vld_ff[ConvStages-1];
   assign demand    = dem_ff;

endmodule

// ----- src/column_precip_partition.sv -----
// From acceptance (start high, busy low): entry, divider, convective and output registers.
// Throughput: one transaction per cycle; busy is never raised and results are never held.
// Depth is set by the phase divider, two quotient bits per stage over 16 bits, plus
// four multiplier stages for the smoothstep and convective demand.
// Reset (synchronous, active high) clears all valid bits and loads the register defaults.
// Depends on ccp_pkg, ccp_phase_div, ccp_water and ccp_convect.
module column_precip_partition (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ccp_pkg::ccp_req_type             req_data,
   output logic                             rsp_valid,
   output ccp_pkg::ccp_rsp_type             rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ccp_pkg::CsrAddrBits-1:0]  paddr,
   input  logic [ccp_pkg::CsrDataBits-1:0]  pwdata,
   output logic [ccp_pkg::CsrDataBits-1:0]  prdata,
   output logic                             pready
);
   import ccp_pkg::*;

   // Configuration registers
   logic [FracBits-1:0]        conv_frac_ff, conv_frac_in;
   logic [FracBits-1:0]        crit_rh_ff, crit_rh_in;
   logic [FracBits-1:0]        resid_rh_ff, resid_rh_in;
   logic [FracBits-1:0]        conv_eff_ff, conv_eff_in;
   logic signed [TempBits-1:0] act_temp_ff, act_temp_in;
   logic signed [TempBits-1:0] full_temp_ff, full_temp_in;
   csr_index_type              csr_idx;
   logic                       csr_wr;
   ccp_cfg_type                cfg;

   // Entry stage
   logic                       accept;
   logic [WaterBits+1:0]       sup_sum;
   logic                       e_vld_ff, e_vld_in;
   ccp_phase_type              e_phase_ff, e_phase_in;
   logic [SupplyBits-1:0]      e_sup_ff, e_sup_in;
   logic [WaterBits-1:0]       e_avail_ff, e_avail_in;
   logic [WaterBits-1:0]       e_plain_ff, e_plain_in;
   logic [WaterBits-1:0]       e_terrain_ff, e_terrain_in;
   logic [RemBits-1:0]         divisor;

   // Alignment delay lines
   logic [SupplyBits-1:0]      sup_dly_ff [DivStages];
   logic [SupplyBits-1:0]      sup_dly_in [DivStages];
   ccp_water_type              wat_dly_ff [AlignDepth];
   ccp_water_type              wat_dly_in [AlignDepth];

   // Submodule outputs
   logic                       div_valid;
   logic [FracBits-1:0]        phase;
   ccp_water_type              water;
   logic                       conv_valid;
   logic [SupplyBits-1:0]      demand;
   ccp_water_type              wat_aligned;

   // Output stage
   logic                       rsp_valid_ff, rsp_valid_in;
   ccp_rsp_type                rsp_data_ff, rsp_data_in;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;

   // Register write decode
   always_comb begin
      csr_idx      = csr_index_type'(paddr[CsrAddrBits-1:2]);
      csr_wr       = psel && penable && pwrite && pready;
      conv_frac_in = conv_frac_ff;
      crit_rh_in   = crit_rh_ff;
      resid_rh_in  = resid_rh_ff;
      conv_eff_in  = conv_eff_ff;
      act_temp_in  = act_temp_ff;
      full_temp_in = full_temp_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_CONV_FRAC: conv_frac_in = pwdata[FracBits-1:0];
            CSR_CRIT_RH:   crit_rh_in   = pwdata[FracBits-1:0];
            CSR_RESID_RH:  resid_rh_in  = pwdata[FracBits-1:0];
            CSR_CONV_EFF:  conv_eff_in  = pwdata[FracBits-1:0];
            CSR_ACT_TEMP:  act_temp_in  = pwdata[TempBits-1:0];
            CSR_FULL_TEMP: full_temp_in = pwdata[TempBits-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_frac_ff <= '0;
         crit_rh_ff   <= CritRhReset;
         resid_rh_ff  <= '0;
         conv_eff_ff  <= '0;
         act_temp_ff  <= '0;
         full_temp_ff <= '0;
      end else begin
         conv_frac_ff <= conv_frac_in;
         crit_rh_ff   <= crit_rh_in;
         resid_rh_ff  <= resid_rh_in;
         conv_eff_ff  <= conv_eff_in;
         act_temp_ff  <= act_temp_in;
         full_temp_ff <= full_temp_in;
      end
   end

   // Register read mux
   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         CSR_CONV_FRAC: prdata = CsrDataBits'(conv_frac_ff);
         CSR_CRIT_RH:   prdata = CsrDataBits'(crit_rh_ff);
         CSR_RESID_RH:  prdata = CsrDataBits'(resid_rh_ff);
         CSR_CONV_EFF:  prdata = CsrDataBits'(conv_eff_ff);
         CSR_ACT_TEMP:  prdata = CsrDataBits'({act_temp_ff});
         CSR_FULL_TEMP: prdata = CsrDataBits'({full_temp_ff});
         default: ;
      endcase
   end

   // Fractions above 1.0 act as 1.0
   always_comb begin
      cfg.conv_frac = clamp_frac(conv_frac_ff);
      cfg.crit_rh   = clamp_frac(crit_rh_ff);
      cfg.resid_rh  = clamp_frac(resid_rh_ff);
      cfg.conv_eff  = clamp_frac(conv_eff_ff);
   end

   // Entry: ramp classification, divider operands, convergent supply
   always_comb begin
      e_vld_in         = accept;
      e_phase_in.ge_hi = (req_data.surface_temp >= full_temp_ff);
      // degenerate ramp or at/below the lower edge gives zero phase unless ge_hi is set
      e_phase_in.zero  = (full_temp_ff <= act_temp_ff) ||
                         (req_data.surface_temp <= act_temp_ff);
      e_phase_in.rem   = RemBits'(req_data.surface_temp - act_temp_ff);
      e_phase_in.quot  = '0;
      sup_sum          = {{2{req_data.convergence[WaterBits-1]}}, req_data.convergence} +
                         {2'b00, req_data.evaporation};
      e_sup_in         = sup_sum[WaterBits+1] ? '0 : sup_sum[SupplyBits-1:0];
      e_avail_in       = req_data.column_water;
      e_plain_in       = req_data.plain_capacity;
      e_terrain_in     = req_data.terrain_capacity;
      divisor          = RemBits'(full_temp_ff - act_temp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= e_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      e_phase_ff   <= e_phase_in;
      e_sup_ff     <= e_sup_in;
      e_avail_ff   <= e_avail_in;
      e_plain_ff   <= e_plain_in;
      e_terrain_ff <= e_terrain_in;
   end

   ccp_phase_div u_phase_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_vld_ff),
      .in_phase  (e_phase_ff),
      .divisor   (divisor),
      .out_valid (div_valid),
      .phase     (phase)
   );

   ccp_water u_water (
      .clock   (clock),
      .avail   (e_avail_ff),
      .plain   (e_plain_ff),
      .terrain (e_terrain_ff),
      .cfg     (cfg),
      .water   (water)
   );

   // Supply waits for the divider; water results wait for the demand
   always_comb begin
      sup_dly_in[0] = e_sup_ff;
      for (int k = 1; k < DivStages; k++) begin
         sup_dly_in[k] = sup_dly_ff[k-1];
      end
      wat_dly_in[0] = water;
      for (int k = 1; k < AlignDepth; k++) begin
         wat_dly_in[k] = wat_dly_ff[k-1];
      end
      wat_aligned = wat_dly_ff[AlignDepth-1];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DivStages; k++) begin
         sup_dly_ff[k] <= sup_dly_in[k];
      end
      for (int k = 0; k < AlignDepth; k++) begin
         wat_dly_ff[k] <= wat_dly_in[k];
      end
   end

   ccp_convect u_convect (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .phase     (phase),
      .supply    (sup_dly_ff[DivStages-1]),
      .conv_eff  (cfg.conv_eff),
      .out_valid (conv_valid),
      .demand    (demand)
   );

   // Output: convective demand capped by the headroom above the residual floor
   always_comb begin
      rsp_valid_in                = conv_valid;
      rsp_data_in.stratiform_rain = wat_aligned.strat;
      rsp_data_in.orographic_rain = wat_aligned.oro;
      rsp_data_in.convective_rain = (demand < {1'b0, wat_aligned.conv_avail}) ?
                                    demand[WaterBits-1:0] : wat_aligned.conv_avail;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/ccp_checker.sv -----
// Port-level assertions for column_precip_partition, attached by the bind below.
// Depends on ccp_pkg and the top level.
module ccp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input ccp_pkg::ccp_req_type req_data,
   input logic                 rsp_valid,
   input ccp_pkg::ccp_rsp_type rsp_data
);
   import ccp_pkg::*;

   logic                 accept;
   logic [WaterBits+1:0] rain_sum;

   assign accept   = start && !busy;
   assign rain_sum = (WaterBits+2)'(rsp_data.stratiform_rain) +
                     (WaterBits+2)'(rsp_data.orographic_rain) +
                     (WaterBits+2)'(rsp_data.convective_rain);

   // Full rate: the block never pushes back
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Every accepted transaction yields a strobe after the fixed latency
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PipeLatency rsp_valid)
      else $error("result strobe missing");

   // No strobe without a transaction accepted at the matching edge
   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PipeLatency))
      else $error("spurious result strobe");

   // The three parts never exceed the column water of their transaction
   a_water_budget: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rain_sum <= (WaterBits+2)'($past(req_data.column_water, PipeLatency))))
      else $error("precipitation exceeds column water");

endmodule

bind column_precip_partition ccp_checker u_ccp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for column_precip_partition: directed and random grid columns
// are checked against an in-bench predictor under several register settings.
// Depends on ccp_pkg and the RTL in src; reads and writes no files.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ccp_pkg::*;

   localparam int              CycleLimit = 200000;
   localparam longint unsigned OneFrac    = 65536;

   // Scoreboard: register shadow, rain predictor and queue of expected rain
   class rain_scoreboard;
      logic [FracBits-1:0] conv_frac = '0;
      logic [FracBits-1:0] crit_rh   = CritRhReset;
      logic [FracBits-1:0] resid_rh  = '0;
      logic [FracBits-1:0] conv_eff  = '0;
      logic [TempBits-1:0] act_temp  = '0;
      logic [TempBits-1:0] full_temp = '0;
      ccp_rsp_type         expected_rain[$];
      int                  mismatch_count = 0;

      function void set_register(csr_index_type idx, logic [CsrDataBits-1:0] value);
         case (idx)
            CSR_CONV_FRAC: conv_frac = value[FracBits-1:0];
            CSR_CRIT_RH:   crit_rh   = value[FracBits-1:0];
            CSR_RESID_RH:  resid_rh  = value[FracBits-1:0];
            CSR_CONV_EFF:  conv_eff  = value[FracBits-1:0];
            CSR_ACT_TEMP:  act_temp  = value[TempBits-1:0];
            CSR_FULL_TEMP: full_temp = value[TempBits-1:0];
            default: ;
         endcase
      endfunction

      // Fractions above 1.0 act as 1.0
      function longint unsigned clamp_one(logic [FracBits-1:0] f);
         return (f > OneFrac) ? OneFrac : longint'(f);
      endfunction

      // Truncating Q1.16 product
      function longint unsigned scale_q16(longint unsigned x, longint unsigned f);
         return (x * f) >> FracShift;
      endfunction

      // Relaxed condensation of the water above a threshold
      function longint unsigned excess_q16(longint unsigned avail, longint unsigned thr,
                                           longint unsigned frac);
         return (avail <= thr) ? 0 : scale_q16(avail - thr, frac);
      endfunction

      function ccp_rsp_type predict_rain(ccp_req_type col);
         longint unsigned avail, plain, terrain, frac, crh;
         longint unsigned cond_plain, cond_terrain, oro, strat, left, floor_w, room;
         longint unsigned phase, inst, supply, demand, conv_rain;
         longint          lo, hi, temp, conv_s, evap_s, net_supply;
         ccp_rsp_type     rain;
         avail   = 64'(col.column_water);
         plain   = 64'(col.plain_capacity);
         terrain = 64'(col.terrain_capacity);
         frac    = clamp_one(conv_frac);
         crh     = clamp_one(crit_rh);

         // Plain and terrain condensation; the terrain-only part is orographic
         cond_plain   = excess_q16(avail, scale_q16(plain, crh), frac);
         cond_terrain = excess_q16(avail, scale_q16(terrain, crh), frac);
         oro   = (cond_terrain > cond_plain) ? cond_terrain - cond_plain : 0;
         strat = cond_terrain - oro;

         // Water left for convection above the residual floor
         left    = (avail > cond_terrain) ? avail - cond_terrain : 0;
         floor_w = scale_q16(plain, clamp_one(resid_rh));
         room    = (left > floor_w) ? left - floor_w : 0;

         // Smoothstep instability; a step when the edges are not ordered
         lo   = longint'($signed(act_temp));
         hi   = longint'($signed(full_temp));
         temp = longint'(col.surface_temp);
         if (hi <= lo) begin
            inst = (temp >= hi) ? OneFrac : 0;
         end else begin
            if (temp <= lo)
               phase = 0;
            else if (temp >= hi)
               phase = OneFrac;
            else
               phase = ((temp - lo) * 65536) / (hi - lo);
            inst = (phase * phase * (3 * OneFrac - 2 * phase)) >> SmoothShift;
         end

         // Convergent supply, floored at zero, then capped by the room left
         conv_s     = longint'(col.convergence);
         evap_s     = longint'(col.evaporation);
         net_supply = conv_s + evap_s;
         supply     = (net_supply > 0) ? net_supply : 0;
         demand     = scale_q16(scale_q16(supply, inst), clamp_one(conv_eff));
         conv_rain  = (demand < room) ? demand : room;

         rain.stratiform_rain = strat[WaterBits-1:0];
         rain.orographic_rain = oro[WaterBits-1:0];
         rain.convective_rain = conv_rain[WaterBits-1:0];
         return rain;
      endfunction

      function void note_column(ccp_req_type col);
         expected_rain.push_back(predict_rain(col));
      endfunction

      function void check_rain(ccp_rsp_type got);
         ccp_rsp_type want;
         if (expected_rain.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected rain transaction: strat %0d oro %0d conv %0d",
                        got.stratiform_rain, got.orographic_rain, got.convective_rain);
            return;
         end
         want = expected_rain.pop_front();
         if (got.stratiform_rain !== want.stratiform_rain ||
             got.orographic_rain !== want.orographic_rain ||
             got.convective_rain !== want.convective_rain) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("rain mismatch: expected strat %0d oro %0d conv %0d, got %0d %0d %0d",
                        want.stratiform_rain, want.orographic_rain, want.convective_rain,
                        got.stratiform_rain, got.orographic_rain, got.convective_rain);
         end
      endfunction

      function int pending();
         return expected_rain.size();
      endfunction
   endclass

   logic                   clock   = 1'b0;
   logic                   reset   = 1'b1;
   logic                   start   = 1'b0;
   ccp_req_type            req_data = '0;
   logic                   psel    = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite  = 1'b0;
   logic [CsrAddrBits-1:0] paddr   = '0;
   logic [CsrDataBits-1:0] pwdata  = '0;
   logic                   busy;
   logic                   rsp_valid;
   ccp_rsp_type            rsp_data;
   logic [CsrDataBits-1:0] prdata;
   logic                   pready;

   rain_scoreboard sb = new();
   int             cycle_count  = 0;
   int             random_sent  = 0;
   int             cur_act      = 0;
   int             cur_full     = 0;

   column_precip_partition dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Accepted transactions on both channels go to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_rain(rsp_data);
         if (start && !busy)
            sb.note_column(req_data);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("column_precip_partition verification failed");
         $finish;
      end
   end

   function automatic ccp_req_type make_column(int water, int plain, int terrain,
                                               int conv, int evap, int temp);
      ccp_req_type col;
      col.column_water     = water[WaterBits-1:0];
      col.plain_capacity   = plain[WaterBits-1:0];
      col.terrain_capacity = terrain[WaterBits-1:0];
      col.convergence      = conv[WaterBits-1:0];
      col.evaporation      = evap[WaterBits-1:0];
      col.surface_temp     = temp[TempBits-1:0];
      return col;
   endfunction

   // Water amounts spread over full range, small values, values up to 2**20 and values near the top
   function automatic logic [WaterBits-1:0] rand_water();
      case ($urandom_range(0, 3))
         0:       return WaterBits'($urandom);
         1:       return WaterBits'($urandom_range(0, 4095));
         2:       return {WaterBits{1'b1}} - WaterBits'($urandom_range(0, 4095));
         default: return WaterBits'($urandom_range(0, 1 << 20));
      endcase
   endfunction

   // Capacity that puts the threshold near the column water about half the time
   function automatic logic [WaterBits-1:0] near_water(logic [WaterBits-1:0] water);
      longint cap;
      if ($urandom_range(0, 1))
         return rand_water();
      cap = (longint'(water) * $urandom_range(40, 160)) / 100;
      return (cap > 24'hFFFFFF) ? {WaterBits{1'b1}} : cap[WaterBits-1:0];
   endfunction

   function automatic ccp_req_type random_column();
      ccp_req_type          col;
      logic [WaterBits-1:0] water;
      logic [TempBits-1:0]  raw_temp;
      int                   lo, hi, base, hi_edge;
      water                = rand_water();
      col.column_water     = water;
      col.plain_capacity   = near_water(water);
      col.terrain_capacity = near_water(water);
      col.evaporation      = rand_water();
      case ($urandom_range(0, 2))
         0:       col.convergence = WaterBits'($urandom);
         1:       col.convergence = WaterBits'($urandom_range(0, 512) - 256 - col.evaporation);
         default: col.convergence = WaterBits'($urandom_range(0, 65535));
      endcase

      // Temperature mostly around the smoothstep edges
      lo = (cur_act < cur_full) ? cur_act : cur_full;
      hi = (cur_act < cur_full) ? cur_full : cur_act;
      case ($urandom_range(0, 9))
         0, 1, 2: raw_temp = TempBits'($urandom);
         3:       raw_temp = lo[TempBits-1:0];
         4:       raw_temp = hi[TempBits-1:0];
         default: begin
            base     = (lo - 256 < -32768) ? -32768 : lo - 256;
            hi_edge  = (hi + 256 > 32767) ? 32767 : hi + 256;
            raw_temp = TempBits'(base + $urandom_range(0, hi_edge - base));
         end
      endcase
      col.surface_temp = raw_temp;
      return col;
   endfunction

   // Present one column and hold it until accepted; random idle cycles in front if may_idle, not for columns 400 to 599
   task automatic send_column(ccp_req_type col, bit may_idle);
      int idle_len;
      if (may_idle && (random_sent < 400 || random_sent >= 600) &&
          $urandom_range(0, 99) < 11) begin
         idle_len = $urandom_range(1, 3);
         @(negedge clock);
         start = 1'b0;
         repeat (idle_len - 1) @(negedge clock);
      end
      @(negedge clock);
      start    = 1'b1;
      req_data = col;
      do @(posedge clock); while (busy);
   endtask

   task automatic run_phase(int count);
      repeat (count) begin
         send_column(random_column(), 1'b1);
         random_sent++;
      end
      @(negedge clock);
      start = 1'b0;
   endtask

   // Register write: setup cycle, then access cycle until pready
   task automatic csr_write(csr_index_type idx, logic [CsrDataBits-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      sb.set_register(idx, value);
   endtask

   // Registers change only with the pipeline drained
   task automatic set_config(int frac, int crh, int rrh, int eff, int act, int full);
      while (sb.pending() != 0) @(posedge clock);
      repeat (PipeLatency + 2) @(posedge clock);
      csr_write(CSR_CONV_FRAC, 32'(frac));
      csr_write(CSR_CRIT_RH,   32'(crh));
      csr_write(CSR_RESID_RH,  32'(rrh));
      csr_write(CSR_CONV_EFF,  32'(eff));
      csr_write(CSR_ACT_TEMP,  {16'h0, act[TempBits-1:0]});
      csr_write(CSR_FULL_TEMP, {16'h0, full[TempBits-1:0]});
      cur_act  = act;
      cur_full = full;
   endtask

   task automatic random_config();
      logic [TempBits-1:0] a, b;
      int                  act, full;
      a    = TempBits'($urandom);
      b    = TempBits'($urandom);
      act  = int'($signed(a));
      full = int'($signed(b));
      // mostly ordered edges, sometimes the step case
      if ($urandom_range(0, 3) != 0 && act > full) begin
         act  = int'($signed(b));
         full = int'($signed(a));
      end
      set_config($urandom_range(0, 131071), $urandom_range(0, 131071),
                 $urandom_range(0, 131071), $urandom_range(0, 131071), act, full);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register defaults: no conversion, no convective efficiency
      run_phase(30);

      // Directed columns under a typical setting
      set_config(40000, 52429, 20000, 50000, -2560, 7680);
      send_column(make_column(0, 0, 0, 0, 0, 0), 1'b0);
      send_column(make_column(16777215, 16777215, 16777215, 8388607, 16777215, 32767), 1'b0);
      send_column(make_column(16777215, 0, 0, 8388607, 0, 7680), 1'b0);
      // terrain lowers the threshold: orographic, with negative supply
      send_column(make_column(16777215, 16777215, 0, -8388608, 0, 7680), 1'b0);
      // terrain raises the threshold: no orographic rain, coldest surface
      send_column(make_column(16777215, 0, 16777215, -8388608, 16777215, -32768), 1'b0);
      // supply exactly zero, then just below zero
      send_column(make_column(100000, 50000, 20000, -1000, 1000, 0), 1'b0);
      send_column(make_column(100000, 50000, 20000, -1001, 1000, 0), 1'b0);
      // water at the stratiform threshold and one above
      send_column(make_column(52429, 65536, 65536, 0, 0, 0), 1'b0);
      send_column(make_column(52430, 65536, 65536, 0, 0, 0), 1'b0);
      // surface temperature at and next to the smoothstep edges, and at the midpoint
      send_column(make_column(4000000, 1000000, 500000, 300000, 200000, -2560), 1'b0);
      send_column(make_column(4000000, 1000000, 500000, 300000, 200000, -2559), 1'b0);
      send_column(make_column(4000000, 1000000, 500000, 300000, 200000, 2560), 1'b0);
      send_column(make_column(4000000, 1000000, 500000, 300000, 200000, 7679), 1'b0);
      send_column(make_column(4000000, 1000000, 500000, 300000, 200000, 7680), 1'b0);
      send_column(make_column(1, 0, 0, 1, 0, 32767), 1'b0);
      send_column(make_column(0, 16777215, 16777215, 8388607, 16777215, 32767), 1'b0);
      send_column(make_column(16777215, 0, 0, 0, 16777215, 20000), 1'b0);
      send_column(make_column(8000000, 9000000, 3000000, 4000000, 100, 3000), 1'b0);
      // convective demand capped by little water
      send_column(make_column(1000, 0, 0, 8388607, 16777215, 7680), 1'b0);
      @(negedge clock);
      start = 1'b0;
      run_phase(120);

      // Extreme settings: full fractions, widest span
      set_config(65536, 65536, 65536, 65536, -32768, 32767);
      run_phase(130);
      // Fractions above one, reversed edges (step)
      set_config(131071, 131071, 131071, 131071, 32767, -32768);
      run_phase(130);
      // All zero, equal edges
      set_config(0, 0, 0, 0, 0, 0);
      run_phase(100);
      // Narrowest ordered span
      set_config(65535, 30000, 65536, 65536, 100, 101);
      run_phase(130);
      repeat (3) begin
         random_config();
         run_phase(140);
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (PipeLatency + 4) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("column_precip_partition verification clean");
      else
         $display("column_precip_partition verification failed");
      $finish;
   end

endmodule
